// ----- design/sma_pkg.sv -----
// Shared types and codes for the stack machine arithmetic unit.
// No dependencies; imported by the top level.
`default_nettype none

package sma_pkg;

    localparam int unsigned DefStackDepth = 256;
    localparam int unsigned WordW         = 32;
    localparam int unsigned OpW           = 3;
    localparam int unsigned StatusW       = 2;

    typedef logic [WordW-1:0]   t_word;
    typedef logic [OpW-1:0]     t_opcode;
    typedef logic [StatusW-1:0] t_status;

    localparam t_opcode OP_PUSH = 3'd0;
    localparam t_opcode OP_ADD  = 3'd1;
    localparam t_opcode OP_SUB  = 3'd2;
    localparam t_opcode OP_MUL  = 3'd3;
    localparam t_opcode OP_DIV  = 3'd4;
    localparam t_opcode OP_MOD  = 3'd5;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_SHORT   = 2'd1;
    localparam t_status ST_DIVZERO = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ----- design/stack_machine_alu_top.sv -----
// Stack machine arithmetic unit: bounded word stack in RAM with add/sub/mul/div/mod.
// Depends on sma_pkg and sma_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: an opcode and a
//   push value. Output channel (o_out_valid / i_out_ready) returns one item per
//   input: the new top of stack (zero when empty), the entry count and a status.
//   One item is worked on at a time. Steps from accept to result register:
//     push, errors and unused opcodes: commit
//     add, sub, mul: ALU/multiply on the second word read at accept, commit
//     div, mod: divider load, 32 iterations of the radix-2 divider, sign fix,
//     commit; the divider loop sets the rate for these opcodes.
//   With a ready receiver the next item is taken in the cycle after the result
//   is registered.
//   The top word is cached in a register, so only the second word is read.
//   The result register frees the input side: a new item is taken while a
//   result waits; the commit of the following item holds until the result is
//   taken. A stalled receiver therefore stalls the block after one more item.
//   Reset empties the stack (count zero); RAM contents are not cleared and
//   no clearing pass is needed.
`default_nettype none

module stack_machine_alu_top #(
    parameter int unsigned STACK_DEPTH = sma_pkg::DefStackDepth
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire sma_pkg::t_opcode               i_opcode,
    input  wire logic signed [31:0]             i_push_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [31:0]                  o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    o_stack_count,
    output sma_pkg::t_status                    o_status
);

    import sma_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_word         r_top;
    t_word         r_res;
    t_opcode       r_op;
    t_status       r_status;
    logic          r_wr;

    logic          r_out_valid;
    t_word         r_out_top;
    logic [CW-1:0] r_out_count;
    t_status       r_out_status;

    t_word         r_quo;
    t_word         r_rem;
    t_word         r_dvs;
    logic          r_neg_q;
    logic          r_neg_r;
    logic [4:0]    r_iter;

    logic          in_accept;
    logic          commit;
    logic          full;
    logic          short;
    logic [CW-1:0] cnt_m2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          ram_wr;
    t_word         rd_data;
    logic [32:0]   rem_sh;
    logic [32:0]   diff;
    t_word         s_abs;
    t_word         t_abs;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign commit     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign full       = (r_count == CW'(STACK_DEPTH));
    assign short      = (r_count < CW'(2));
    assign cnt_m2     = r_count - CW'(2);
    assign rd_addr    = cnt_m2[AW-1:0];
    assign wr_addr    = (r_op == OP_PUSH) ? r_count[AW-1:0] : cnt_m2[AW-1:0];
    assign ram_wr     = commit && r_wr;

    assign s_abs  = rd_data[31] ? (~rd_data + 32'd1) : rd_data;
    assign t_abs  = r_top[31] ? (~r_top + 32'd1) : r_top;
    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    sma_ram #(
        .WIDTH (WordW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_res),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_opcode inside {[OP_ADD:OP_MUL]} && !short) begin
                        n_state = S_EXEC;
                    end else if (i_opcode inside {OP_DIV, OP_MOD} && !short
                                 && (r_top != '0)) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_EXEC: n_state = (r_op inside {OP_DIV, OP_MOD}) ? S_DIV : S_DONE;
            S_DIV:  n_state = (r_iter == 5'd31) ? S_FIX : S_DIV;
            S_FIX:  n_state = S_DONE;
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                    if (r_wr) begin
                        n_count = (r_op == OP_PUSH) ? r_count + CW'(1) : r_count - CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_op  <= i_opcode;
                    r_res <= t_word'(i_push_value);
                    case (i_opcode)
                        OP_PUSH: begin
                            r_status <= full ? ST_FULL : ST_OK;
                            r_wr     <= !full;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                            if (short) begin
                                r_status <= ST_SHORT;
                                r_wr     <= 1'b0;
                            end else if (i_opcode inside {OP_DIV, OP_MOD}
                                         && (r_top == '0)) begin
                                r_status <= ST_DIVZERO;
                                r_wr     <= 1'b0;
                            end else begin
                                r_status <= ST_OK;
                                r_wr     <= 1'b1;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_wr     <= 1'b0;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ADD:  r_res <= rd_data + r_top;
                    OP_SUB:  r_res <= rd_data - r_top;
                    OP_MUL:  r_res <= t_word'(rd_data * r_top);
                    default: r_res <= r_res;
                endcase
                r_quo   <= s_abs;
                r_dvs   <= t_abs;
                r_rem   <= '0;
                r_neg_q <= rd_data[31] ^ r_top[31];
                r_neg_r <= rd_data[31];
                r_iter  <= '0;
            end
            S_DIV: begin
                r_iter <= r_iter + 5'd1;
                if (!diff[32]) begin
                    r_rem <= diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            S_FIX: begin
                if (r_op == OP_DIV) begin
                    r_res <= r_neg_q ? (~r_quo + 32'd1) : r_quo;
                end else begin
                    r_res <= r_neg_r ? (~r_rem + 32'd1) : r_rem;
                end
            end
            S_DONE: begin
                if (ram_wr) begin
                    r_top <= r_res;
                end
            end
            default: r_res <= r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_count  <= n_count;
            r_out_status <= r_status;
            if (n_count == '0) begin
                r_out_top <= '0;
            end else if (r_wr) begin
                r_out_top <= r_res;
            end else begin
                r_out_top <= r_top;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_stack_count = r_out_count;
    assign o_status      = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_SHORT) |-> o_stack_count < CW'(2))
        else $error("too-short status with two or more entries");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_stack_count == CW'(STACK_DEPTH))
        else $error("full status on a stack that is not full");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stack_count == '0) |-> o_top_value == '0)
        else $error("nonzero top on empty stack");

    a_commit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && !r_wr |=> r_count == $past(r_count))
        else $error("count changed on a step without a write");

endmodule

`default_nettype wire

// ----- design/sma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sma_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
